@@ rtl/ccr_pkg.sv @@
`timescale 1ns / 1ps

package ccr_pkg;

  localparam int RF_DEPTH = 256;
  localparam int RF_AW    = $clog2(RF_DEPTH);
  localparam int TICKS_W  = 17;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [7:0]  PAGE_REGS     = 8'h22;
  localparam logic [6:0]  WINDOW_HI     = 7'h11;
  localparam logic [15:0] ADDR_HOST_ST  = 16'h2300;
  localparam logic [15:0] ADDR_COPR_ST  = 16'h2301;
  localparam logic [15:0] ADDR_VERSION  = 16'h230E;

  localparam logic [RF_AW-1:0] REG_CTRL     = 8'h00;
  localparam logic [RF_AW-1:0] REG_HCLR     = 8'h02;
  localparam logic [RF_AW-1:0] REG_VEC_LO   = 8'h03;
  localparam logic [RF_AW-1:0] REG_VEC_HI   = 8'h04;
  localparam logic [RF_AW-1:0] REG_HSET     = 8'h09;
  localparam logic [RF_AW-1:0] REG_IRQ_EN   = 8'h0A;
  localparam logic [RF_AW-1:0] REG_CCLR     = 8'h0B;

  localparam logic [7:0] VERSION_CODE   = 8'd35;
  localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;
  localparam logic [7:0] HOST_RD_MASK   = 8'h5F;
  localparam logic [7:0] COPR_RD_MASK   = 8'h0F;
  localparam logic [7:0] CTRL_RESET     = 8'h20;

  typedef struct packed {
    logic               use_mem;
    logic [7:0]         rdata;
    logic               irq;
    logic               running;
    logic               hold;
    logic               start;
    logic [15:0]        vector;
    logic [TICKS_W-1:0] ticks;
  } beat_t;

  function automatic logic [7:0] rf_reset_value(input logic [RF_AW-1:0] idx);
    logic [7:0] v;
    case (idx)
      8'h00:   v = CTRL_RESET;
      8'h21:   v = 8'h01;
      8'h22:   v = 8'h02;
      8'h23:   v = 8'h03;
      8'h28:   v = 8'h0F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/coprocessor_control_registers_core.sv @@
`timescale 1ns / 1ps
// coprocessor control registers, host side
// input channel: in_valid / in_stall carries one beat of operation, address,
// write_data and master_cycles; operation selects read, write or advance
// output channel: out_valid / out_stall carries exactly one result beat per
// input beat, in order
// pipeline: two register stages, the read stage (synchronous ram) and the
// output register; a result beat moves from the read stage to the output
// register whenever the output register is empty or not stalled
// throughput: one beat per cycle unless the output stalls; writes go to the
// ram at acceptance and the status flags, run state and cycle remainder
// update in the same cycle, so the next beat sees them at once
// the tick division is a reciprocal multiply on the accept cycle
// reset: the result pipeline empties, flags and remainder clear, and the
// register file reads its reset values through per-entry valid bits, with no
// clearing pass; beats are taken as soon as reset is released
// stall: when the output register is full and stalled, the read stage holds
// its beat and in_stall rises until the output drains
module coprocessor_control_registers_core
  import ccr_pkg::*;
#(
  parameter int MASTER_PER_TICK = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [15:0]         address,
  input  logic [7:0]          write_data,
  input  logic [15:0]         master_cycles,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          read_data,
  output logic                irq_line,
  output logic                running,
  output logic                cpu_hold_pulse,
  output logic                cpu_start_pulse,
  output logic [15:0]         start_vector,
  output logic [TICKS_W-1:0]  ticks_granted
);

  localparam int REM_W     = (MASTER_PER_TICK > 1) ? $clog2(MASTER_PER_TICK) : 1;
  localparam int DIV_SHIFT = TICKS_W + REM_W + 1;
  localparam int PROD_W    = TICKS_W + DIV_SHIFT + 1;
  localparam logic [DIV_SHIFT:0] RECIP =
    (DIV_SHIFT+1)'(((64'd1 << DIV_SHIFT) + MASTER_PER_TICK - 1) / MASTER_PER_TICK);

  logic [7:0]          mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld;
  logic [7:0]          rd_q;

  logic [7:0]       reg_ctrl, reg_vec_lo, reg_vec_hi, reg_hset, reg_irq_en;
  logic [1:0]       host_flags;
  logic [3:0]       copr_flags;
  logic             run_flag;
  logic [REM_W-1:0] rem;

  logic [1:0]       host_flags_next;
  logic [3:0]       copr_flags_next;
  logic             run_flag_next;
  logic [REM_W-1:0] rem_next;

  logic             p1_valid;
  beat_t            p1, p1_next, p1_out, out_q;

  logic             acc, p1_move, out_load, wr_en, rd_en;
  logic [RF_AW-1:0] idx;

  logic [TICKS_W-1:0] total, quot, qm, rem_calc;
  logic [PROD_W-1:0]  prod;

  assign idx      = address[RF_AW-1:0];
  assign out_load = !out_valid || !out_stall;
  assign p1_move  = p1_valid && out_load;
  assign in_stall = p1_valid && !out_load;
  assign acc      = in_valid && !in_stall;
  assign wr_en    = acc && (operation == OP_WRITE) && (address[15:8] == PAGE_REGS);
  assign rd_en    = acc && (operation == OP_READ);

  assign total    = TICKS_W'(master_cycles) + TICKS_W'(rem);
  assign prod     = PROD_W'(total) * PROD_W'(RECIP);
  assign quot     = prod[DIV_SHIFT +: TICKS_W];
  assign qm       = TICKS_W'(quot * TICKS_W'(MASTER_PER_TICK));
  assign rem_calc = total - qm;

  always_comb begin
    logic [7:0] irq_en_new;
    irq_en_new      = reg_irq_en;
    host_flags_next = host_flags;
    copr_flags_next = copr_flags;
    run_flag_next   = run_flag;
    rem_next        = rem;
    p1_next         = '0;

    case (operation)
      OP_READ: begin
        if (address[15:9] != WINDOW_HI) begin
          p1_next.rdata = UNMAPPED_BYTE;
        end else if (address == ADDR_HOST_ST) begin
          p1_next.rdata = (reg_hset & HOST_RD_MASK)
                        | {host_flags[1], 1'b0, host_flags[0], 5'b0};
        end else if (address == ADDR_COPR_ST) begin
          p1_next.rdata = (reg_ctrl & COPR_RD_MASK) | {copr_flags, 4'b0};
        end else if (address == ADDR_VERSION) begin
          p1_next.rdata = VERSION_CODE;
        end else if (!address[8]) begin
          p1_next.use_mem = 1'b1;
        end
      end
      OP_WRITE: begin
        if (address[15:8] == PAGE_REGS) begin
          case (idx)
            REG_CTRL: begin
              if (reg_ctrl[5] && !write_data[5]) begin
                p1_next.start  = 1'b1;
                p1_next.vector = {reg_vec_hi, reg_vec_lo};
                rem_next       = '0;
              end else if (!reg_ctrl[5] && write_data[5]) begin
                p1_next.hold = 1'b1;
              end
              if (write_data[7]) copr_flags_next[3] = 1'b1;
              run_flag_next = (write_data[6:5] == 2'b00);
              if (write_data[6:5] != 2'b00) rem_next = '0;
            end
            REG_HCLR: host_flags_next = host_flags & ~{write_data[7], write_data[5]};
            REG_HSET: if (write_data[7]) host_flags_next[1] = 1'b1;
            REG_IRQ_EN: irq_en_new = write_data;
            REG_CCLR: copr_flags_next = copr_flags & ~write_data[7:4];
            default: ;
          endcase
        end
      end
      OP_ADVANCE: begin
        if (run_flag && (master_cycles != '0)) begin
          p1_next.ticks = quot;
          rem_next      = rem_calc[REM_W-1:0];
        end
      end
      default: ;
    endcase

    p1_next.irq     = copr_flags_next[3] && irq_en_new[7];
    p1_next.running = run_flag_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= write_data;
    end
    if (rd_en) begin
      rd_q <= vld[idx] ? mem[idx] : rf_reset_value(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      reg_ctrl   <= CTRL_RESET;
      reg_vec_lo <= '0;
      reg_vec_hi <= '0;
      reg_hset   <= '0;
      reg_irq_en <= '0;
      host_flags <= '0;
      copr_flags <= '0;
      run_flag   <= 1'b0;
      rem        <= '0;
      p1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[idx] <= 1'b1;
        case (idx)
          REG_CTRL:   reg_ctrl   <= write_data;
          REG_VEC_LO: reg_vec_lo <= write_data;
          REG_VEC_HI: reg_vec_hi <= write_data;
          REG_HSET:   reg_hset   <= write_data;
          REG_IRQ_EN: reg_irq_en <= write_data;
          default: ;
        endcase
      end
      if (acc) begin
        host_flags <= host_flags_next;
        copr_flags <= copr_flags_next;
        run_flag   <= run_flag_next;
        rem        <= rem_next;
      end
      if (acc) begin
        p1_valid <= 1'b1;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= p1_valid;
      end
    end
  end

  always_comb begin
    p1_out = p1;
    if (p1.use_mem) p1_out.rdata = rd_q;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1 <= p1_next;
    end
    if (p1_move) begin
      out_q <= p1_out;
    end
  end

  assign read_data       = out_q.rdata;
  assign irq_line        = out_q.irq;
  assign running         = out_q.running;
  assign cpu_hold_pulse  = out_q.hold;
  assign cpu_start_pulse = out_q.start;
  assign start_vector    = out_q.vector;
  assign ticks_granted   = out_q.ticks;

endmodule

@@ rtl/ccr_checker.sv @@
`timescale 1ns / 1ps

module ccr_checker
  import ccr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         read_data,
  input logic               irq_line,
  input logic               running,
  input logic               cpu_hold_pulse,
  input logic               cpu_start_pulse,
  input logic [15:0]        start_vector,
  input logic [TICKS_W-1:0] ticks_granted
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(ticks_granted)
      && $stable(start_vector) && $stable(running))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result pipeline not empty after reset");

  a_pulses: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(cpu_hold_pulse && cpu_start_pulse)
      && (cpu_start_pulse || start_vector == '0))
    else $error("hold and start pulses inconsistent");

  a_ticks_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && ticks_granted != '0 |-> running && !cpu_hold_pulse && !cpu_start_pulse)
    else $error("ticks granted while stopped or on a write");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(in_valid || out_valid))
    else $error("input stalled with empty output");

endmodule

bind coprocessor_control_registers_core ccr_checker u_ccr_checker (.*);

@@ sim/ccr_reply_checker.sv @@
`timescale 1ns / 1ps

module ccr_reply_checker
  import ccr_pkg::*;
#(
  parameter int MASTER_PER_TICK = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [15:0]        address,
  input  logic [7:0]         write_data,
  input  logic [15:0]        master_cycles,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         read_data,
  input  logic               irq_line,
  input  logic               running,
  input  logic               cpu_hold_pulse,
  input  logic               cpu_start_pulse,
  input  logic [15:0]        start_vector,
  input  logic [TICKS_W-1:0] ticks_granted,
  output int                 failures,
  output int                 outstanding
);

  localparam logic [15:0] WINDOW_LO      = 16'h2200;
  localparam logic [15:0] WINDOW_TOP     = 16'h23FF;
  localparam logic [7:0]  HOST_FLAG_MASK = 8'hA0;
  localparam logic [7:0]  COPR_FLAG_MASK = 8'hF0;

  typedef struct packed {
    logic [7:0]         rdata;
    logic               irq;
    logic               running;
    logic               hold;
    logic               start;
    logic [15:0]        vector;
    logic [TICKS_W-1:0] ticks;
  } reply_t;

  logic [7:0] regs [RF_DEPTH];
  logic [7:0] host_flags;
  logic [7:0] copr_flags;
  logic       run_flag;
  logic [7:0] remainder;
  reply_t     expected_q [$];

  task automatic clear_model();
    for (int i = 0; i < RF_DEPTH; i++) regs[i] = 8'h00;
    regs[REG_CTRL] = 8'h20;
    regs[8'h21]    = 8'h01;
    regs[8'h22]    = 8'h02;
    regs[8'h23]    = 8'h03;
    regs[8'h28]    = 8'h0F;
    host_flags = 8'h00;
    copr_flags = 8'h00;
    run_flag   = 1'b0;
    remainder  = 8'h00;
  endtask

  function automatic reply_t predict_reply(input logic [1:0] op, input logic [15:0] addr,
                                           input logic [7:0] data, input logic [15:0] cycles);
    reply_t     r;
    logic [7:0] idx;
    logic [7:0] prior;
    int         total;
    r   = '0;
    idx = addr[7:0];
    case (op)
      OP_READ: begin
        if (addr < WINDOW_LO || addr > WINDOW_TOP)
          r.rdata = UNMAPPED_BYTE;
        else if (addr == ADDR_HOST_ST)
          r.rdata = (regs[REG_HSET] & HOST_RD_MASK) | (host_flags & HOST_FLAG_MASK);
        else if (addr == ADDR_COPR_ST)
          r.rdata = (regs[REG_CTRL] & COPR_RD_MASK) | (copr_flags & COPR_FLAG_MASK);
        else if (addr == ADDR_VERSION)
          r.rdata = VERSION_CODE;
        else if (addr[8])
          r.rdata = 8'h00;
        else
          r.rdata = regs[idx];
      end
      OP_WRITE: begin
        if (addr[15:8] == PAGE_REGS) begin
          prior     = regs[idx];
          regs[idx] = data;
          case (idx)
            REG_CTRL: begin
              if (prior[5] && !data[5]) begin
                r.start   = 1'b1;
                r.vector  = {regs[REG_VEC_HI], regs[REG_VEC_LO]};
                remainder = 8'h00;
              end else if (!prior[5] && data[5]) begin
                r.hold = 1'b1;
              end
              if (data[7]) copr_flags[7] = 1'b1;
              run_flag = (data[6:5] == 2'b00);
              if (!run_flag) remainder = 8'h00;
            end
            REG_HCLR: host_flags &= ~(data & HOST_FLAG_MASK);
            REG_HSET: if (data[7]) host_flags[7] = 1'b1;
            REG_CCLR: copr_flags &= ~(data & COPR_FLAG_MASK);
            default: ;
          endcase
        end
      end
      OP_ADVANCE: begin
        if (cycles != 16'd0 && run_flag) begin
          total     = int'(cycles) + int'(remainder);
          r.ticks   = TICKS_W'(total / MASTER_PER_TICK);
          remainder = 8'(total % MASTER_PER_TICK);
        end
      end
      default: ;
    endcase
    r.irq     = copr_flags[7] & regs[REG_IRQ_EN][7];
    r.running = run_flag;
    return r;
  endfunction

  function automatic int check_field(input string what, input logic [TICKS_W-1:0] want,
                                     input logic [TICKS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int     bad;
    bad = 0;
    if (rst) begin
      clear_model();
      expected_q.delete();
      failures <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_reply(operation, address, write_data, master_cycles));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat expected none actual rdata %0h ticks %0h", $time,
                   read_data, ticks_granted);
          bad = 1;
        end else begin
          want = expected_q.pop_front();
          bad += check_field("read_data", TICKS_W'(want.rdata), TICKS_W'(read_data));
          bad += check_field("irq_line", TICKS_W'(want.irq), TICKS_W'(irq_line));
          bad += check_field("running", TICKS_W'(want.running), TICKS_W'(running));
          bad += check_field("cpu_hold_pulse", TICKS_W'(want.hold),
                             TICKS_W'(cpu_hold_pulse));
          bad += check_field("cpu_start_pulse", TICKS_W'(want.start),
                             TICKS_W'(cpu_start_pulse));
          bad += check_field("start_vector", TICKS_W'(want.vector),
                             TICKS_W'(start_vector));
          bad += check_field("ticks_granted", want.ticks, ticks_granted);
        end
      end
      failures <= failures + bad;
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ccr_pkg::*;

  localparam int          TICK_DIV       = 2;
  localparam int          QUIET_LIMIT    = 1000;
  localparam int          SQUEEZE_CYCLES = 80;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         operation     = OP_READ;
  logic [15:0]        address       = 16'h0000;
  logic [7:0]         write_data    = 8'h00;
  logic [15:0]        master_cycles = 16'h0000;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [7:0]         read_data;
  logic               irq_line;
  logic               running;
  logic               cpu_hold_pulse;
  logic               cpu_start_pulse;
  logic [15:0]        start_vector;
  logic [TICKS_W-1:0] ticks_granted;
  int                 failures;
  int                 outstanding;
  int                 quiet = 0;
  bit                 src_gaps  = 1'b1;
  bit                 sink_gaps = 1'b1;
  bit                 squeeze   = 1'b0;

  coprocessor_control_registers_core #(.MASTER_PER_TICK(TICK_DIV)) dut (.*);

  ccr_reply_checker #(.MASTER_PER_TICK(TICK_DIV)) reply_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input logic [15:0] cycles);
    int gap;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    address       <= addr;
    write_data    <= data;
    master_cycles <= cycles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_address();
    logic [7:0] hot [7] = '{REG_CTRL, REG_HCLR, REG_VEC_LO, REG_VEC_HI,
                            REG_HSET, REG_IRQ_EN, REG_CCLR};
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return {8'h23, 8'($urandom)};
      2:       return $urandom_range(0, 1) ? ADDR_HOST_ST : ADDR_COPR_ST;
      3:       return {PAGE_REGS, 8'($urandom)};
      4:       return ADDR_VERSION;
      default: return {PAGE_REGS, hot[$urandom_range(0, 6)]};
    endcase
  endfunction

  // sink: random stall per beat, one long hold-off on request
  initial begin
    int hold;
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        hold    = SQUEEZE_CYCLES;
      end else begin
        hold = sink_gaps ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] cyc;
    int          pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // status window, version and unmapped edges
    send_beat(OP_READ, ADDR_HOST_ST, 8'h00, 16'h0000);
    send_beat(OP_READ, ADDR_COPR_ST, 8'hFF, 16'hFFFF);
    send_beat(OP_READ, ADDR_VERSION, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h2302, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h23FF, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h0000, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'hFFFF, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h21FF, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h2400, 8'h00, 16'h0000);
    send_beat(OP_READ, 16'h2228, 8'h00, 16'h0000);
    // vector, stopped advance, irq enable, then release
    send_beat(OP_WRITE, {PAGE_REGS, REG_VEC_LO}, 8'h34, 16'h0000);
    send_beat(OP_WRITE, {PAGE_REGS, REG_VEC_HI}, 8'h12, 16'h0000);
    send_beat(OP_ADVANCE, 16'h0000, 8'h00, 16'd100);
    send_beat(OP_WRITE, {PAGE_REGS, REG_IRQ_EN}, 8'h80, 16'h0000);
    send_beat(OP_WRITE, {PAGE_REGS, REG_CTRL}, 8'h80, 16'h0000);
    send_beat(OP_ADVANCE, 16'h0000, 8'h00, 16'd3);
    send_beat(OP_ADVANCE, 16'h0000, 8'h00, 16'd0);
    send_beat(OP_ADVANCE, 16'hFFFF, 8'hFF, 16'hFFFF);
    // host and coprocessor flag set and clear
    send_beat(OP_WRITE, {PAGE_REGS, REG_HSET}, 8'hFF, 16'h0000);
    send_beat(OP_READ, ADDR_HOST_ST, 8'h00, 16'h0000);
    send_beat(OP_WRITE, {PAGE_REGS, REG_HCLR}, 8'hA0, 16'h0000);
    send_beat(OP_WRITE, {PAGE_REGS, REG_CCLR}, 8'hF0, 16'h0000);
    // hold, release while stopped, an ignored write, a register write, unused code
    send_beat(OP_WRITE, {PAGE_REGS, REG_CTRL}, 8'h20, 16'h0000);
    send_beat(OP_WRITE, {PAGE_REGS, REG_CTRL}, 8'h40, 16'h0000);
    send_beat(OP_WRITE, 16'h2300, 8'hAA, 16'h0000);
    send_beat(OP_WRITE, 16'h22FF, 8'hFF, 16'h0000);
    send_beat(OP_UNUSED, 16'h22FF, 8'hFF, 16'hFFFF);

    for (int n = 0; n < 400; n++) begin
      if (n % 40 == 0) begin
        src_gaps  = $urandom_range(0, 2) != 0;
        sink_gaps = $urandom_range(0, 2) != 0;
      end
      if (n == 150) begin
        squeeze  = 1'b1;
        src_gaps = 1'b0;
      end
      pick = $urandom_range(0, 99);
      addr = pick_address();
      data = 8'($urandom);
      case ($urandom_range(0, 7))
        0:       cyc = 16'h0000;
        1:       cyc = 16'hFFFF;
        2, 3:    cyc = 16'($urandom);
        default: cyc = 16'($urandom_range(1, 40));
      endcase
      if (pick < 35) begin
        op = OP_READ;
      end else if (pick < 70) begin
        op = OP_WRITE;
        if (addr == {PAGE_REGS, REG_CTRL} && $urandom_range(0, 1)) data[6:5] = 2'b00;
      end else if (pick < 95) begin
        op = OP_ADVANCE;
      end else begin
        op   = $urandom_range(0, 1) ? OP_UNUSED : OP_WRITE;
        addr = 16'($urandom);
      end
      send_beat(op, addr, data, cyc);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ccr_pkg.sv
rtl/coprocessor_control_registers_core.sv
rtl/ccr_checker.sv
sim/ccr_reply_checker.sv
sim/testbench.sv
